/* rtl/pnch_pkg.sv */
// Package for the parameter-name hash: constants, shared types and the CRC step.
`timescale 1ns / 1ps

package pnch_pkg;

    localparam int NAME_CHARS = 8;
    localparam int SEEN_W     = $clog2(NAME_CHARS + 1);
    localparam int CODE_W     = 7;
    localparam int SLOT_COUNT = 4;
    localparam int CODE_MAX   = 5;
    localparam int FILL_W     = 3;
    localparam int HASH_W     = 16;

    localparam logic [HASH_W-1:0] CRC_POLY   = 16'h8F57;
    localparam logic [CODE_W-1:0] CODE_SPACE = 7'd78;
    localparam logic [CODE_W-1:0] CODE_UNDER = 7'd74;
    localparam logic [CODE_W-1:0] CODE_DASH  = 7'd72;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    // Classification of one character as seen by the slot logic.
    typedef struct packed {
        logic              has_code;
        logic              is_dot;
        logic [CODE_W-1:0] code;
    } char_class_t;

    typedef logic [CODE_W-1:0] slot_t;

    // Seven message bits, MSB first, through the CRC register.
    function automatic logic [HASH_W-1:0] crc_code(input logic [HASH_W-1:0] crc_in,
                                                   input logic [CODE_W-1:0] code);
        logic [HASH_W-1:0] crc;
        logic              fb;
        crc = crc_in;
        for (int b = CODE_W - 1; b >= 0; b--)
        begin
            fb  = code[b] ^ crc[HASH_W-1];
            crc = {crc[HASH_W-2:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ CRC_POLY;
            end
        end
        return crc;
    endfunction

endpackage

/* rtl/pnch_char_if.sv */
// Handshake channel that carries one character beat of a parameter name.
`timescale 1ns / 1ps

interface pnch_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       char_valid;
    logic       name_end;

    modport source (output valid, output char_code, output char_valid, output name_end,
                    input ready);
    modport sink (input valid, input char_code, input char_valid, input name_end,
                  output ready);
endinterface

/* rtl/pnch_hash_if.sv */
// Handshake channel that carries one finished name hash.
`timescale 1ns / 1ps

interface pnch_hash_if;
    logic        valid;
    logic        ready;
    logic [15:0] name_hash;

    modport source (output valid, output name_hash, input ready);
    modport sink (input valid, input name_hash, output ready);
endinterface

/* rtl/parameter_name_crc_hash_core.sv */
// Top level of the parameter-name hash: input register, slot state, CRC and result register.
`timescale 1ns / 1ps

// Usage
// The char_in channel carries one beat per character of a parameter name. char_valid
// says whether char_code holds a character; name_end marks the last beat of the name,
// and a character on that beat is counted before the hash is formed. Only the first
// eight characters count; letters are folded to uppercase and mapped to codes, and a
// dot bumps the previous code. The hash_out channel delivers one beat per name: the
// CRC-16 (polynomial 0x8F57, start 0, MSB first) over the first four codes, or zero
// for a name with no character.
// A beat is captured in the input register and, once it leaves it, updates the slot
// state; on a name end the hash is written to the result register as the beat leaves.
// Throughput: one beat per cycle, unless a name end waits for the result register.
// When hash_out stalls, character beats still flow into the slot state; only a second
// name end waits in the input register until the result register is taken.
// Reset clears all handshake state and sets the slots to the space code.

module parameter_name_crc_hash_core (
    input  logic          clk,
    input  logic          rst_n,
    pnch_char_if.sink     char_in,
    pnch_hash_if.source   hash_out
);
    import pnch_pkg::*;

    // Input register stage.
    logic              in_vld_reg;
    logic [7:0]        in_char_reg;
    logic              in_cvalid_reg;
    logic              in_end_reg;

    // Name state.
    slot_t             slots_reg [SLOT_COUNT];
    slot_t             slots_next [SLOT_COUNT];
    logic [FILL_W-1:0] filled_reg;
    logic [FILL_W-1:0] filled_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;

    // Result register.
    logic              out_vld_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    char_class_t       cls;
    logic              advance;
    logic              take;
    logic [HASH_W-1:0] crc;

    pnch_char_map u_map (
        .char_code  (in_char_reg),
        .char_class (cls)
    );

    // A beat leaves the input register unless it ends a name and the result
    // register is still held by the receiver.
    assign advance = in_vld_reg
                     && (!in_end_reg || !out_vld_reg || hash_out.ready);
    assign char_in.ready = !in_vld_reg || advance;

    assign hash_out.valid     = out_vld_reg;
    assign hash_out.name_hash = hash_reg;

    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            slots_next[k] = slots_reg[k];
        end
        filled_next = filled_reg;
        seen_next   = seen_reg;
        take        = in_cvalid_reg && (seen_reg < SEEN_W'(NAME_CHARS));

        if (take)
        begin
            seen_next = seen_reg + 1'b1;
            if (filled_reg < FILL_W'(CODE_MAX))
            begin
                if (cls.is_dot)
                begin
                    // A dot bumps the latest code; at the start, or with no code yet,
                    // it does nothing.
                    if (seen_reg != '0 && filled_reg != '0
                        && filled_reg <= FILL_W'(SLOT_COUNT))
                    begin
                        for (int k = 0; k < SLOT_COUNT; k++)
                        begin
                            if (FILL_W'(k + 1) == filled_reg)
                            begin
                                slots_next[k] = slots_reg[k] + 1'b1;
                            end
                        end
                    end
                end
                else if (cls.has_code)
                begin
                    for (int k = 0; k < SLOT_COUNT; k++)
                    begin
                        if (FILL_W'(k) == filled_reg)
                        begin
                            slots_next[k] = cls.code;
                        end
                    end
                    filled_next = filled_reg + 1'b1;
                end
            end
        end

        crc = '0;
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            crc = crc_code(crc, slots_next[k]);
        end
        hash_next = (seen_next != '0) ? crc : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_vld_reg <= char_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_in.ready && char_in.valid)
        begin
            in_char_reg   <= char_in.char_code;
            in_cvalid_reg <= char_in.char_valid;
            in_end_reg    <= char_in.name_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                slots_reg[k] <= CODE_SPACE;
            end
            filled_reg  <= '0;
            seen_reg    <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                if (in_end_reg)
                begin
                    // Name complete: start the next name from a clean state.
                    for (int k = 0; k < SLOT_COUNT; k++)
                    begin
                        slots_reg[k] <= CODE_SPACE;
                    end
                    filled_reg <= '0;
                    seen_reg   <= '0;
                end
                else
                begin
                    for (int k = 0; k < SLOT_COUNT; k++)
                    begin
                        slots_reg[k] <= slots_next[k];
                    end
                    filled_reg <= filled_next;
                    seen_reg   <= seen_next;
                end
            end

            if (advance && in_end_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (hash_out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_end_reg)
        begin
            hash_reg <= hash_next;
        end
    end
endmodule

/* rtl/pnch_char_map.sv */
// Character mapper: folds case and turns one byte into a name code or a dot mark.
`timescale 1ns / 1ps

module pnch_char_map (
    input  logic [7:0]               char_code,
    output pnch_pkg::char_class_t    char_class
);
    import pnch_pkg::*;

    logic [7:0] upper;
    logic [7:0] letter_off;
    logic [7:0] digit_off;

    always_comb
    begin
        if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z)
        begin
            upper = char_code - CASE_GAP;
        end
        else
        begin
            upper = char_code;
        end
        letter_off = upper - CH_UPPER_A;
        digit_off  = upper - CH_DIGIT_0;

        char_class.has_code = 1'b0;
        char_class.is_dot   = 1'b0;
        char_class.code     = CODE_SPACE;
        priority if (upper == CH_DOT)
        begin
            char_class.is_dot = 1'b1;
        end
        else if (upper == CH_SPACE)
        begin
            char_class.has_code = 1'b1;
            char_class.code     = CODE_SPACE;
        end
        else if (upper == CH_UNDER)
        begin
            char_class.has_code = 1'b1;
            char_class.code     = CODE_UNDER;
        end
        else if (upper == CH_DASH)
        begin
            char_class.has_code = 1'b1;
            char_class.code     = CODE_DASH;
        end
        else if (upper >= CH_UPPER_A && upper <= CH_UPPER_Z)
        begin
            // Letters take the even codes 20 to 70.
            char_class.has_code = 1'b1;
            char_class.code     = {1'b0, letter_off[4:0], 1'b0} + 7'd20;
        end
        else if (upper >= CH_DIGIT_0 && upper <= CH_DIGIT_9)
        begin
            char_class.has_code = 1'b1;
            char_class.code     = {2'b00, digit_off[3:0], 1'b0};
        end
        else
        begin
            char_class.has_code = 1'b0;
        end
    end
endmodule

/* verif/parameter_name_crc_hash_core_tb.sv */
// Self-checking testbench for the parameter-name CRC hash core.
`timescale 1ns / 1ps

module parameter_name_crc_hash_core_tb;

    import pnch_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung. The
    // longest legitimate quiet stretch is the deliberate receiver hold-off below.
    localparam int STALL_LIMIT     = 3000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_BEATS    = 1050;

    // One beat of the character channel as the driver queues it.
    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       name_end;
    } name_beat_t;

    logic clk;
    logic rst_n;

    pnch_char_if char_bus ();
    pnch_hash_if hash_bus ();

    parameter_name_crc_hash_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_in  (char_bus),
        .hash_out (hash_bus)
    );

    // Beats waiting to be offered, and hashes the predictor says are owed.
    name_beat_t  pending_beats[$];
    logic [15:0] hashes_owed[$];

    // Predictor state: the four hashed code slots, the number of codes mapped so far
    // and the number of characters taken from the current name.
    slot_t       name_slots[SLOT_COUNT];
    int unsigned codes_mapped;
    int unsigned chars_taken;

    int          error_count;
    int          hashes_checked;
    int          burst_left;
    int          gap_left;
    int          hold_left;
    bit          hold_done;
    int          stall_mode;
    int          mode_left;
    int unsigned rx_cycle;
    int          quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Starts a fresh name: every slot holds the space code until something is mapped.
    task automatic clear_name();
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            name_slots[k] = CODE_SPACE;
        end
        codes_mapped = 0;
        chars_taken  = 0;
    endtask

    // Advances the predictor by one accepted beat and, on a name end, records the
    // hash that must come out. A character on the end beat is taken first.
    task automatic absorb_name_beat(input name_beat_t beat);
        logic [7:0]  ch;
        logic [15:0] crc;
        slot_t       code;
        bit          mapped;
        int unsigned pos;
        bit          fb;
        if (beat.char_valid && chars_taken < NAME_CHARS)
        begin
            pos = chars_taken;
            chars_taken++;
            ch = beat.char_code;
            if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            begin
                ch = ch - CASE_GAP;
            end
            // Once five codes are in, the rest of the name only counts characters.
            if (codes_mapped < CODE_MAX)
            begin
                mapped = 1'b1;
                code   = CODE_SPACE;
                if (ch == CH_DOT)
                begin
                    // A dot bumps the previous code, but only where there is one and
                    // it sits in a hashed slot; a leading dot does nothing.
                    mapped = 1'b0;
                    if (pos > 0 && codes_mapped > 0 && codes_mapped <= SLOT_COUNT)
                    begin
                        name_slots[codes_mapped - 1] = name_slots[codes_mapped - 1] + 1'b1;
                    end
                end
                else if (ch == CH_SPACE)
                begin
                    code = CODE_SPACE;
                end
                else if (ch == CH_UNDER)
                begin
                    code = CODE_UNDER;
                end
                else if (ch == CH_DASH)
                begin
                    code = CODE_DASH;
                end
                else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
                begin
                    code = slot_t'(2 * (int'(ch) - int'(CH_UPPER_A) + 10));
                end
                else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
                begin
                    code = slot_t'(2 * (int'(ch) - int'(CH_DIGIT_0)));
                end
                else
                begin
                    // Unmapped bytes still used up a character position above.
                    mapped = 1'b0;
                end
                if (mapped)
                begin
                    if (codes_mapped < SLOT_COUNT)
                    begin
                        name_slots[codes_mapped] = code;
                    end
                    codes_mapped++;
                end
            end
        end
        if (beat.name_end)
        begin
            // CRC-16 over the seven bits of each slot, MSB first, from zero. A name
            // with no character at all hashes to zero.
            crc = '0;
            if (chars_taken > 0)
            begin
                for (int k = 0; k < SLOT_COUNT; k++)
                begin
                    for (int b = CODE_W - 1; b >= 0; b--)
                    begin
                        fb  = name_slots[k][b] ^ crc[15];
                        crc = {crc[14:0], 1'b0};
                        if (fb)
                        begin
                            crc = crc ^ CRC_POLY;
                        end
                    end
                end
            end
            hashes_owed.push_back(crc);
            clear_name();
        end
    endtask

    task automatic queue_beat(input logic [7:0] ch, input logic cv, input logic ne);
        name_beat_t beat;
        beat.char_code  = ch;
        beat.char_valid = cv;
        beat.name_end   = ne;
        pending_beats.push_back(beat);
    endtask

    task automatic queue_text(input string text, input bit end_on_last);
        for (int i = 0; i < text.len(); i++)
        begin
            queue_beat(text[i], 1'b1, end_on_last && (i == text.len() - 1));
        end
    endtask

    // Character mix for random names: mostly mappable, with dots and stray bytes.
    function automatic logic [7:0] pick_name_char();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            return CH_UPPER_A + 8'($urandom_range(0, 25));
        end
        else if (sel < 50)
        begin
            return CH_LOWER_A + 8'($urandom_range(0, 25));
        end
        else if (sel < 65)
        begin
            return CH_DIGIT_0 + 8'($urandom_range(0, 9));
        end
        else if (sel < 70)
        begin
            return CH_SPACE;
        end
        else if (sel < 75)
        begin
            return CH_UNDER;
        end
        else if (sel < 80)
        begin
            return CH_DASH;
        end
        else if (sel < 90)
        begin
            return CH_DOT;
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Gap before the next burst: often none at all, so that back-to-back runs of
    // beats occur, otherwise short, and now and then a longer pause.
    function automatic int pick_gap();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
        begin
            return 0;
        end
        else if (sel < 9)
        begin
            return $urandom_range(1, 6);
        end
        return $urandom_range(10, 25);
    endfunction

    // Stimulus and end of run. All beats are queued before reset is released; the
    // driver then works through them at its own pace.
    initial
    begin
        int counted;
        int len;
        int unsigned sel;
        bit end_on_char;

        rst_n               = 1'b0;
        char_bus.valid      = 1'b0;
        char_bus.char_code  = '0;
        char_bus.char_valid = 1'b0;
        char_bus.name_end   = 1'b0;
        hash_bus.ready      = 1'b0;
        error_count         = 0;
        hashes_checked      = 0;
        hold_left           = 0;
        hold_done           = 1'b0;
        quiet_cycles        = 0;
        clear_name();

        // An empty name gives zero.
        queue_beat(8'h00, 1'b0, 1'b1);
        // A beat with neither character nor end is a no-op.
        queue_beat(8'hFF, 1'b0, 1'b0);
        // Leading dot, a dot with no code yet and unmapped bytes only: four spaces.
        queue_text(".#.", 1'b0);
        queue_beat(8'hFF, 1'b1, 1'b1);
        // Every mapping kind up to a fifth code, a dot after it, a sixth code, an
        // idle beat inside the name and a ninth character on the end beat.
        queue_text("aZ09_.-.", 1'b0);
        queue_beat(8'h5A, 1'b0, 1'b0);
        queue_beat("q", 1'b1, 1'b1);
        // Dots stacking on the space code behind a high byte, then a separate end beat.
        queue_text(" ", 1'b0);
        queue_beat(8'h80, 1'b1, 1'b0);
        queue_text("..z", 1'b0);
        queue_beat(8'h00, 1'b0, 1'b1);
        // Dash bumped by a dot, and a zero byte on the end beat.
        queue_text("m-.", 1'b0);
        queue_beat(8'h00, 1'b1, 1'b1);

        // Random names, mostly within the counted length, a few running past it.
        counted = 0;
        while (counted < RANDOM_BEATS)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 4)
            begin
                len = 0;
            end
            else if (sel < 90)
            begin
                len = $urandom_range(1, 9);
            end
            else
            begin
                len = $urandom_range(10, 16);
            end
            end_on_char = (len > 0) && ($urandom_range(0, 1) == 1);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                begin
                    queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
                queue_beat(pick_name_char(), 1'b1, end_on_char && (i == len - 1));
            end
            counted += len;
            if (!end_on_char)
            begin
                queue_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                counted++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_beats.size() != 0 || hashes_owed.size() != 0)
        begin
            @(posedge clk);
        end
        // After the last owed hash is taken, the drain cycles catch any stray beat.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Character driver. A beat offered stays put until the core takes it; between
    // bursts of random length the channel goes idle with junk on the payload.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_bus.valid      <= 1'b0;
            char_bus.char_code  <= '0;
            char_bus.char_valid <= 1'b0;
            char_bus.name_end   <= 1'b0;
            burst_left = $urandom_range(1, 24);
            gap_left   = 0;
        end
        else
        begin
            if (char_bus.valid && char_bus.ready)
            begin
                absorb_name_beat(pending_beats.pop_front());
            end
            if (char_bus.valid && !char_bus.ready)
            begin
                // Stalled: the beat on the bus is held unchanged.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                char_bus.valid      <= 1'b0;
                char_bus.char_code  <= 8'($urandom_range(0, 255));
                char_bus.char_valid <= 1'($urandom_range(0, 1));
                char_bus.name_end   <= 1'($urandom_range(0, 1));
            end
            else if (pending_beats.size() != 0)
            begin
                char_bus.valid      <= 1'b1;
                char_bus.char_code  <= pending_beats[0].char_code;
                char_bus.char_valid <= pending_beats[0].char_valid;
                char_bus.name_end   <= pending_beats[0].name_end;
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = pick_gap();
                end
            end
            else
            begin
                char_bus.valid <= 1'b0;
            end
        end
    end

    // Hash monitor and receiver. Each hash taken is checked against the oldest one
    // owed. Ready follows a stall pattern that changes mode every so often, and once
    // in the run the receiver holds off for a long stretch while characters keep
    // coming, so that the result register and then the input register fill up.
    always @(posedge clk or negedge rst_n)
    begin
        logic        ready_next;
        logic [15:0] want;
        if (!rst_n)
        begin
            hash_bus.ready <= 1'b0;
            stall_mode = 0;
            mode_left  = $urandom_range(30, 150);
            rx_cycle   = 0;
        end
        else
        begin
            rx_cycle++;
            if (hash_bus.valid && hash_bus.ready)
            begin
                if (hashes_owed.size() == 0)
                begin
                    $error("name_hash: unexpected beat, expected none, actual 0x%04h",
                           hash_bus.name_hash);
                    error_count++;
                end
                else
                begin
                    want = hashes_owed.pop_front();
                    if (hash_bus.name_hash !== want)
                    begin
                        $error("name_hash mismatch: expected 0x%04h, actual 0x%04h",
                               want, hash_bus.name_hash);
                        error_count++;
                    end
                end
                hashes_checked++;
                if (!hold_done && hashes_checked == HOLD_OFF_AFTER)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_OFF_CYCLES;
                end
            end

            if (mode_left > 0)
            begin
                mode_left--;
            end
            else
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(30, 150);
            end

            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (stall_mode)
                    0: ready_next = 1'b1;
                    1: ready_next = 1'($urandom_range(0, 1));
                    2: ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = rx_cycle[2];
                endcase
            end
            hash_bus.ready <= ready_next;
        end
    end

    // Watchdog: a hung core shows up as a long run with no beat on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_bus.valid && char_bus.ready) || (hash_bus.valid && hash_bus.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
rtl/pnch_pkg.sv
rtl/pnch_char_if.sv
rtl/pnch_hash_if.sv
rtl/pnch_char_map.sv
rtl/parameter_name_crc_hash_core.sv
verif/parameter_name_crc_hash_core_tb.sv
